// File: hdl/pta_pkg.sv
// Shared types and constants for the palindromic tree block.
// No dependencies; every other file in hdl/ imports this package.
package pta_pkg;

    localparam int LETTER_W = 5;
    localparam int OUT_W    = 13;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [OUT_W-1:0]    out_word_t;

endpackage

// File: hdl/pta_letter_store.sv
// Letter memory: one write port, one read port with registered read data.
// Depends on pta_pkg for the letter type.
module pta_letter_store #(
    parameter int DEPTH = 4097,
    parameter int AW    = 13
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  pta_pkg::letter_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output pta_pkg::letter_t rd_data
);
    import pta_pkg::*;

    letter_t mem [DEPTH];
    letter_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/pta_node_store.sv
// Per-node memories: length, suffix link and the key (parent node, letter)
// that proves a child table entry genuine. Depends on pta_pkg.
module pta_node_store #(
    parameter int DEPTH = 4098,
    parameter int NW    = 13,
    parameter int LW    = 13
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [NW-1:0]    wr_addr,
    input  logic [LW-1:0]    wr_len,
    input  logic [NW-1:0]    wr_link,
    input  logic [NW-1:0]    wr_parent,
    input  pta_pkg::letter_t wr_letter,
    input  logic [NW-1:0]    rd_addr,
    output logic [LW-1:0]    rd_len,
    output logic [NW-1:0]    rd_link,
    output logic [NW-1:0]    rd_parent,
    output pta_pkg::letter_t rd_letter
);
    import pta_pkg::*;

    logic [LW-1:0] len_mem    [DEPTH];
    logic [NW-1:0] link_mem   [DEPTH];
    logic [NW-1:0] parent_mem [DEPTH];
    letter_t       letter_mem [DEPTH];

    logic [LW-1:0] rd_len_reg;
    logic [NW-1:0] rd_link_reg;
    logic [NW-1:0] rd_parent_reg;
    letter_t       rd_letter_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            len_mem[wr_addr]    <= wr_len;
            link_mem[wr_addr]   <= wr_link;
            parent_mem[wr_addr] <= wr_parent;
            letter_mem[wr_addr] <= wr_letter;
        end
        rd_len_reg    <= len_mem[rd_addr];
        rd_link_reg   <= link_mem[rd_addr];
        rd_parent_reg <= parent_mem[rd_addr];
        rd_letter_reg <= letter_mem[rd_addr];
    end

    assign rd_len    = rd_len_reg;
    assign rd_link   = rd_link_reg;
    assign rd_parent = rd_parent_reg;
    assign rd_letter = rd_letter_reg;

endmodule

// File: hdl/pta_child_store.sv
// Child table memory indexed by node * alphabet + letter, registered read.
// Depends on pta_pkg; entries are never cleared, the owner checks them.
module pta_child_store #(
    parameter int DEPTH = 106548,
    parameter int AW    = 17,
    parameter int NW    = 13
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [NW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [NW-1:0] rd_data
);
    import pta_pkg::*;

    logic [NW-1:0] mem [DEPTH];
    logic [NW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/palindromic_tree_append.sv
// Palindromic tree (eertree) builder, one letter per command beat.
// Usage: drive letter and raise start while busy is low; the beat is taken
// at that clock edge. The result appears on the result ports for exactly one
// cycle with done high; the receiver cannot stall it, so it must sample then.
// An ignored letter (store full, or outside the alphabet) reports in the next
// cycle and busy stays low. Otherwise the block walks suffix links: a
// candidate too long to fit inside the string passes the issue and length
// states, one whose mirror letter it reads and compares also passes the
// compare state, and the odd root needs only the issue state. The child
// lookup follows: address multiply, child read, node key read, decision. A
// new node needs a second walk and lookup of the same kind. This single
// sequencer and its memory ports take no new letter until the current one is
// finished.
// busy is high from the accepting edge until the cycle in which done is shown,
// when a new beat may already be taken.
// Reset (rst_n low, asynchronous) restores the two roots and empty counters at
// once. Child table entries are never cleared: an entry counts only when it
// names an existing node whose stored parent and letter match, so no clearing
// pass is needed and the block accepts a beat right after reset.
module palindromic_tree_append #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pta_pkg::letter_t  letter,
    output logic              done,
    output pta_pkg::out_word_t suffix_pal_len,
    output pta_pkg::out_word_t suffix_node,
    output logic              is_new_pal,
    output pta_pkg::out_word_t distinct_count,
    output logic              store_full
);
    import pta_pkg::*;

    localparam int NODE_DEPTH  = MAX_LEN + 2;
    localparam int STORE_DEPTH = MAX_LEN + 1;
    localparam int CHILD_DEPTH = NODE_DEPTH * ALPHABET;
    localparam int SW          = $clog2(STORE_DEPTH);
    localparam int NW          = $clog2(NODE_DEPTH);
    localparam int CNT_W       = $clog2(NODE_DEPTH + 1);
    localparam int LW          = $clog2(MAX_LEN + 1);
    localparam int CW          = $clog2(CHILD_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_W_ISSUE,
        S_W_LEN,
        S_W_CMP,
        S_SLOT,
        S_CH_RD,
        S_CH_KEY,
        S_CH_EVAL
    } state_t;

    state_t         state_reg;
    logic [NW-1:0]  letter_count_reg;
    logic [CNT_W-1:0] node_count_reg;
    logic [NW-1:0]  last_node_reg;
    logic [LW-1:0]  last_len_reg;
    letter_t        cur_reg;
    logic [SW-1:0]  endpos_reg;
    logic [NW-1:0]  v_reg;
    logic [LW-1:0]  vlen_reg;
    logic [NW-1:0]  vlink_reg;
    logic           walk2_reg;
    logic [NW-1:0]  parent_reg;
    logic [NW-1:0]  parent_link_reg;
    logic [LW-1:0]  fresh_len_reg;
    logic [CW-1:0]  slot_reg;
    logic [CW-1:0]  parent_slot_reg;
    logic [NW-1:0]  u_reg;
    logic           uvalid_reg;

    logic           done_reg;
    out_word_t      pal_len_reg;
    out_word_t      node_out_reg;
    logic           is_new_reg;
    out_word_t      distinct_reg;
    logic           full_reg;

    // Memory ports
    logic           letter_we;
    logic [SW-1:0]  letter_rd_addr;
    letter_t        letter_rd_data;
    logic           node_we;
    logic [NW-1:0]  node_rd_addr;
    logic [LW-1:0]  node_rd_len;
    logic [NW-1:0]  node_rd_link;
    logic [NW-1:0]  node_rd_parent;
    letter_t        node_rd_letter;
    logic           child_we;
    logic [NW-1:0]  child_rd_data;

    // Shared compare/address unit signals
    logic           accept;
    logic           in_alpha;
    logic           is_full;
    logic [NW-1:0]  v_clamp;
    logic [LW-1:0]  len_cur;
    logic [NW-1:0]  link_cur;
    logic           can_wrap;
    logic [SW-1:0]  p_calc;
    logic [CW-1:0]  slot_calc;
    logic           u_ok;
    logic           key_hit;

    assign accept   = start && !busy;
    assign in_alpha = 32'(letter) < ALPHABET;
    assign is_full  = 32'(letter_count_reg) == STORE_DEPTH;
    assign v_clamp  = (32'(v_reg) >= 32'(node_count_reg)) ? NW'(1) : v_reg;

    // Node 0 is the even root and is not held in the node memory.
    assign len_cur  = (v_reg == '0) ? '0 : node_rd_len;
    assign link_cur = (v_reg == '0) ? NW'(1) : node_rd_link;
    assign can_wrap = 32'(endpos_reg) >= 32'(len_cur) + 32'd2;
    assign p_calc   = SW'(32'(endpos_reg) - 32'(len_cur) - 32'd1);
    assign slot_calc = CW'(32'(v_reg) * ALPHABET + 32'(cur_reg));

    assign u_ok    = (child_rd_data >= NW'(2))
                  && (32'(child_rd_data) < 32'(node_count_reg));
    assign key_hit = uvalid_reg && (node_rd_parent == v_reg) && (node_rd_letter == cur_reg);

    always_comb
    begin
        letter_we      = accept && !is_full && in_alpha;
        letter_rd_addr = p_calc;
        node_rd_addr   = (state_reg == S_CH_KEY) ? child_rd_data : v_clamp;
        node_we        = (state_reg == S_CH_EVAL) && walk2_reg;
        child_we       = (state_reg == S_CH_EVAL) && walk2_reg;
    end

    pta_letter_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (SW)
    ) u_letters (
        .clk     (clk),
        .wr_en   (letter_we),
        .wr_addr (SW'(letter_count_reg)),
        .wr_data (letter),
        .rd_addr (letter_rd_addr),
        .rd_data (letter_rd_data)
    );

    // A single-letter palindrome links to the even root; every longer one links
    // to a child that already exists.
    pta_node_store #(
        .DEPTH (NODE_DEPTH),
        .NW    (NW),
        .LW    (LW)
    ) u_nodes (
        .clk       (clk),
        .wr_en     (node_we),
        .wr_addr   (NW'(node_count_reg)),
        .wr_len    (fresh_len_reg),
        .wr_link   ((parent_reg == NW'(1)) ? '0 : u_reg),
        .wr_parent (parent_reg),
        .wr_letter (cur_reg),
        .rd_addr   (node_rd_addr),
        .rd_len    (node_rd_len),
        .rd_link   (node_rd_link),
        .rd_parent (node_rd_parent),
        .rd_letter (node_rd_letter)
    );

    pta_child_store #(
        .DEPTH (CHILD_DEPTH),
        .AW    (CW),
        .NW    (NW)
    ) u_children (
        .clk     (clk),
        .wr_en   (child_we),
        .wr_addr (parent_slot_reg),
        .wr_data (NW'(node_count_reg)),
        .rd_addr (slot_reg),
        .rd_data (child_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            letter_count_reg <= NW'(1);
            node_count_reg   <= CNT_W'(2);
            last_node_reg    <= '0;
            last_len_reg     <= '0;
            walk2_reg        <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_full || !in_alpha)
                        begin
                            done_reg     <= 1'b1;
                            pal_len_reg  <= OUT_W'(32'(last_len_reg));
                            node_out_reg <= OUT_W'(32'(last_node_reg));
                            is_new_reg   <= 1'b0;
                            distinct_reg <= OUT_W'(32'(node_count_reg) - 32'd2);
                            full_reg     <= is_full;
                        end
                        else
                        begin
                            cur_reg          <= letter;
                            endpos_reg       <= SW'(letter_count_reg);
                            letter_count_reg <= letter_count_reg + NW'(1);
                            v_reg            <= last_node_reg;
                            walk2_reg        <= 1'b0;
                            state_reg        <= S_W_ISSUE;
                        end
                    end
                end
                S_W_ISSUE:
                begin
                    v_reg <= v_clamp;
                    // The odd root wraps any letter.
                    if (v_clamp == NW'(1))
                    begin
                        state_reg <= S_SLOT;
                    end
                    else
                    begin
                        state_reg <= S_W_LEN;
                    end
                end
                S_W_LEN:
                begin
                    vlen_reg  <= len_cur;
                    vlink_reg <= link_cur;
                    if (can_wrap)
                    begin
                        state_reg <= S_W_CMP;
                    end
                    else
                    begin
                        v_reg     <= link_cur;
                        state_reg <= S_W_ISSUE;
                    end
                end
                S_W_CMP:
                begin
                    if (letter_rd_data == cur_reg)
                    begin
                        state_reg <= S_SLOT;
                    end
                    else
                    begin
                        v_reg     <= vlink_reg;
                        state_reg <= S_W_ISSUE;
                    end
                end
                S_SLOT:
                begin
                    slot_reg <= slot_calc;
                    if (!walk2_reg)
                    begin
                        parent_reg      <= v_reg;
                        fresh_len_reg   <= (v_reg == NW'(1)) ? LW'(1) : vlen_reg + LW'(2);
                        parent_link_reg <= (v_reg == NW'(1)) ? '0 : vlink_reg;
                    end
                    state_reg <= S_CH_RD;
                end
                S_CH_RD:
                begin
                    state_reg <= S_CH_KEY;
                end
                S_CH_KEY:
                begin
                    u_reg      <= child_rd_data;
                    uvalid_reg <= u_ok;
                    state_reg  <= S_CH_EVAL;
                end
                S_CH_EVAL:
                begin
                    if (walk2_reg)
                    begin
                        node_count_reg <= node_count_reg + CNT_W'(1);
                        last_node_reg  <= NW'(node_count_reg);
                        last_len_reg   <= fresh_len_reg;
                        done_reg       <= 1'b1;
                        pal_len_reg    <= OUT_W'(32'(fresh_len_reg));
                        node_out_reg   <= OUT_W'(32'(node_count_reg));
                        is_new_reg     <= 1'b1;
                        distinct_reg   <= OUT_W'(32'(node_count_reg) - 32'd1);
                        full_reg       <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                    else if (key_hit)
                    begin
                        last_node_reg <= u_reg;
                        last_len_reg  <= node_rd_len;
                        done_reg      <= 1'b1;
                        pal_len_reg   <= OUT_W'(32'(node_rd_len));
                        node_out_reg  <= OUT_W'(32'(u_reg));
                        is_new_reg    <= 1'b0;
                        distinct_reg  <= OUT_W'(32'(node_count_reg) - 32'd2);
                        full_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                    else if (32'(node_count_reg) < NODE_DEPTH)
                    begin
                        // New palindrome: find its suffix link by a second walk.
                        walk2_reg       <= 1'b1;
                        parent_slot_reg <= slot_reg;
                        v_reg           <= parent_link_reg;
                        state_reg       <= S_W_ISSUE;
                    end
                    else
                    begin
                        last_node_reg <= '0;
                        last_len_reg  <= '0;
                        done_reg      <= 1'b1;
                        pal_len_reg   <= '0;
                        node_out_reg  <= '0;
                        is_new_reg    <= 1'b0;
                        distinct_reg  <= OUT_W'(32'(node_count_reg) - 32'd2);
                        full_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = state_reg != S_IDLE;
    assign done           = done_reg;
    assign suffix_pal_len = pal_len_reg;
    assign suffix_node    = node_out_reg;
    assign is_new_pal     = is_new_reg;
    assign distinct_count = distinct_reg;
    assign store_full     = full_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while the sequencer is still busy");

    a_new_node_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_new_pal) |-> (suffix_node == distinct_count + OUT_W'(1)))
        else $error("new node index does not follow the distinct count");

    a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
        (done && store_full) |-> !is_new_pal)
        else $error("ignored letter reported a new palindrome");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("sequencer left idle without a command beat");

    a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(node_count_reg) >= 32'd2) && (32'(node_count_reg) <= NODE_DEPTH))
        else $error("node count out of range");

endmodule
